### hdl/synth_voice_allocator_assert.svh
// ---------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent checks clocked on clk and disabled during reset (rst_n low).
// ---------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Check that expr holds at every rising clock edge.
`define SVA_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define SVA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVA_ALWAYS(lbl, expr, msg)
`define SVA_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/sva_pkg.sv
// ---------------------------------------------------------------------------
// Voice allocator package
// Request and result types, opcodes, event kinds and cell select codes.
// ---------------------------------------------------------------------------
package sva_pkg;

  localparam int VOICES_DEF   = 9;
  localparam int CHANNELS_DEF = 16;

  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_SET_RES  = 3'd2;
  localparam logic [2:0] OP_SET_PRI  = 3'd3;
  localparam logic [2:0] OP_ALL_OFF  = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] chan;
    logic [6:0] note_key;
    logic [6:0] setting_value;
  } sva_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] voice_id;
    logic [3:0] voice_chan;
    logic [6:0] voice_key;
    logic       last_result;
  } sva_out_t;

  // What a list cell loads at the next edge.
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_LOAD  = 2'd3
  } sva_sel_t;

endpackage

### hdl/sva_cell.sv
// ---------------------------------------------------------------------------
// Voice list cell
// One entry of a voice list; takes data from either neighbor or a new entry.
// ---------------------------------------------------------------------------
module sva_cell
  import sva_pkg::*;
#(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  sva_sel_t     sel,
  input  logic [W-1:0] rst_val,
  input  logic [W-1:0] left_i,
  input  logic [W-1:0] right_i,
  input  logic [W-1:0] load_i,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= rst_val;
    end else begin
      case (sel)
        SEL_LEFT:  q_r <= left_i;
        SEL_RIGHT: q_r <= right_i;
        SEL_LOAD:  q_r <= load_i;
        default:   q_r <= q_r;
      endcase
    end
  end

  assign q = q_r;

endmodule

### hdl/synth_voice_allocator.sv
// ---------------------------------------------------------------------------
// Synth voice allocator
// Assigns a fixed pool of voices to note events, stealing when none is free.
// ---------------------------------------------------------------------------
// The block takes one request at a time and answers with one or more result
// items, the final one marked by last_result. Voices live in two rows of
// cells: the active row (newest voice in cell 0, each cell holding voice,
// channel and key) and the free row (oldest freed voice in cell 0). A
// request is registered and then handled in S_EXEC: note-on with a free
// voice, note-off, set reserve and set priority finish there; all-off moves
// to S_ALLOFF, which gives one stop per active voice (a single result when
// none is active); a note-on that must steal rotates the full active row
// once past the head cell in S_SCAN to pick a victim, then, if one was
// found, gives the stop in S_STEAL_STOP and the start in S_STEAL_START.
// Each result waits while the output register is stalled. The per-channel
// count, reserve, priority and over-reserve tables are read at one channel
// per cycle.
// ---------------------------------------------------------------------------
module synth_voice_allocator
  import sva_pkg::*;
#(
  parameter int VOICES   = VOICES_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sva_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sva_out_t out_data
);

  localparam int VW = $clog2(VOICES);
  localparam int LW = $clog2(VOICES + 1);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AD = VW + 11;

  typedef enum logic [5:0] {
    S_IDLE        = 6'b000001,
    S_EXEC        = 6'b000010,
    S_SCAN        = 6'b000100,
    S_STEAL_STOP  = 6'b001000,
    S_STEAL_START = 6'b010000,
    S_ALLOFF      = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    L_HOLD   = 2'd0,
    L_PUSH   = 2'd1,
    L_REMOVE = 2'd2,
    L_ROT    = 2'd3
  } list_cmd_t;

  typedef enum logic [2:0] {
    T_NONE   = 3'd0,
    T_UP     = 3'd1,
    T_DN     = 3'd2,
    T_SETRES = 3'd3,
    T_SETPRI = 3'd4,
    T_CLEAR  = 3'd5
  } tab_op_t;

  state_t        state_r, state_nxt;
  sva_in_t       req_r;
  sva_out_t      out_r, res;
  logic          out_valid_r;
  logic          slot_free, emit, in_acc;

  // Voice rows
  logic [AD-1:0] act_q [VOICES];
  logic [VW-1:0] fr_q  [VOICES];
  sva_sel_t      act_sel [VOICES];
  sva_sel_t      fr_sel  [VOICES];
  logic [LW-1:0] act_len_r, fr_len_r;
  list_cmd_t     act_cmd, fr_cmd;
  logic [VW-1:0] act_pos;
  logic [AD-1:0] act_new;
  logic [VW-1:0] fr_new;

  // Channel tables
  logic [4:0]    cnt_r [CHANNELS];
  logic [6:0]    res_r [CHANNELS];
  logic [6:0]    pri_r [CHANNELS];
  logic          flg_r [CHANNELS];
  tab_op_t       tab_op;
  logic [CW-1:0] tab_a;
  logic [4:0]    cur_cnt, cnt_up, cnt_dn;
  logic          flag_up, flag_dn;

  // Steal search
  logic          bflag_r, bflag_nxt;
  logic [6:0]    bprio_r, bprio_nxt;
  logic [VW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] steal_v_r, steal_v_nxt;

  // Note-off match
  logic [VW-1:0] hit_idx, sel_idx;
  logic          hit;
  logic [AD-1:0] sel_cell;
  logic [CW-1:0] rch, head_ch, sel_ch;
  logic          chan_ok, cand;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rch     = req_r.chan[CW-1:0];
  assign chan_ok = ({1'b0, req_r.chan} < 5'(CHANNELS));
  assign head_ch = act_q[0][CW+6:7];

  // ---- Active row: cell 0 is the newest voice ----
  for (genvar j = 0; j < VOICES; j++) begin : g_act
    always_comb begin
      case (act_cmd)
        L_PUSH:   act_sel[j] = (j == 0) ? SEL_LOAD : SEL_LEFT;
        L_REMOVE: act_sel[j] = (VW'(j) >= act_pos) ? SEL_RIGHT : SEL_HOLD;
        L_ROT:    act_sel[j] = SEL_RIGHT;
        default:  act_sel[j] = SEL_HOLD;
      endcase
    end
    sva_cell #(.W(AD)) u_act (
      .clk     (clk),
      .rst_n   (rst_n),
      .sel     (act_sel[j]),
      .rst_val ('0),
      .left_i  ((j == 0) ? act_new : act_q[(j == 0) ? 0 : j - 1]),
      .right_i ((j == VOICES - 1) ? act_q[0] : act_q[(j == VOICES - 1) ? 0 : j + 1]),
      .load_i  (act_new),
      .q       (act_q[j])
    );
  end

  // ---- Free row: cell 0 is the oldest freed voice ----
  for (genvar j = 0; j < VOICES; j++) begin : g_fr
    always_comb begin
      case (fr_cmd)
        L_REMOVE: fr_sel[j] = SEL_RIGHT;
        L_PUSH:   fr_sel[j] = (LW'(j) == fr_len_r) ? SEL_LOAD : SEL_HOLD;
        default:  fr_sel[j] = SEL_HOLD;
      endcase
    end
    sva_cell #(.W(VW)) u_fr (
      .clk     (clk),
      .rst_n   (rst_n),
      .sel     (fr_sel[j]),
      .rst_val (VW'(j)),
      .left_i  (fr_q[j]),
      .right_i (fr_q[(j == VOICES - 1) ? j : j + 1]),
      .load_i  (fr_new),
      .q       (fr_q[j])
    );
  end

  // First active voice matching channel and key, newest first.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = VOICES - 1; j >= 0; j--) begin
      if ((LW'(j) < act_len_r) && (act_q[j][10:7] == req_r.chan) &&
          (act_q[j][6:0] == req_r.note_key)) begin
        hit     = 1'b1;
        hit_idx = VW'(j);
      end
    end
  end

  assign sel_idx  = (state_r == S_STEAL_STOP) ? best_r : hit_idx;
  assign sel_cell = act_q[sel_idx];
  assign sel_ch   = sel_cell[CW+6:7];

  // Table read port and saturating count updates.
  assign cur_cnt = cnt_r[tab_a];
  assign cnt_up  = (cur_cnt == 5'd31) ? cur_cnt : cur_cnt + 5'd1;
  assign cnt_dn  = (cur_cnt == 5'd0) ? cur_cnt : cur_cnt - 5'd1;
  assign flag_up = ({2'b0, cnt_up} > res_r[tab_a]);
  assign flag_dn = ({2'b0, cnt_dn} > res_r[tab_a]);

  // Head voice is a better victim on an equal flag with no higher priority,
  // or when it is over reserve and the best so far is not.
  assign cand = ((flg_r[head_ch] == bflag_r) && (bprio_r >= pri_r[head_ch])) ||
                (flg_r[head_ch] && !bflag_r);

  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    res         = '0;
    act_cmd     = L_HOLD;
    act_pos     = '0;
    act_new     = {VW'(0), req_r.chan, req_r.note_key};
    fr_cmd      = L_HOLD;
    fr_new      = sel_cell[AD-1 -: VW];
    tab_op      = T_NONE;
    tab_a       = rch;
    bflag_nxt   = bflag_r;
    bprio_nxt   = bprio_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    idx_nxt     = idx_r;
    steal_v_nxt = steal_v_r;
    res.last_result = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end

      S_EXEC: begin
        if ((req_r.op <= OP_SET_PRI) && !chan_ok) begin
          // drop events on channels that do not exist
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          case (req_r.op)
            OP_NOTE_ON: begin
              if (fr_len_r != '0) begin
                if (slot_free) begin
                  fr_cmd         = L_REMOVE;
                  act_cmd        = L_PUSH;
                  act_new        = {fr_q[0], req_r.chan, req_r.note_key};
                  tab_op         = T_UP;
                  emit           = 1'b1;
                  res.event_kind = EV_START;
                  res.voice_id   = 4'(fr_q[0]);
                  res.voice_chan = req_r.chan;
                  res.voice_key  = req_r.note_key;
                  state_nxt      = S_IDLE;
                end
              end else begin
                // seed the search with the requesting channel
                bflag_nxt = flg_r[rch];
                bprio_nxt = pri_r[rch];
                found_nxt = 1'b0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_NOTE_OFF: begin
              if (slot_free) begin
                emit = 1'b1;
                if (hit) begin
                  act_cmd        = L_REMOVE;
                  act_pos        = hit_idx;
                  fr_cmd         = L_PUSH;
                  tab_op         = T_DN;
                  res.event_kind = EV_STOP;
                  res.voice_id   = 4'(sel_cell[AD-1 -: VW]);
                  res.voice_chan = req_r.chan;
                  res.voice_key  = req_r.note_key;
                end
                state_nxt = S_IDLE;
              end
            end
            OP_SET_RES: begin
              if (slot_free) begin
                tab_op    = T_SETRES;
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            OP_SET_PRI: begin
              if (slot_free) begin
                tab_op    = T_SETPRI;
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            OP_ALL_OFF: begin
              state_nxt = S_ALLOFF;
            end
            default: begin
              if (slot_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // look at the head cell, then rotate the full row by one
        tab_a   = head_ch;
        act_cmd = L_ROT;
        if (cand) begin
          bflag_nxt = flg_r[head_ch];
          bprio_nxt = pri_r[head_ch];
          best_nxt  = idx_r;
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + VW'(1);
        if (idx_r == VW'(VOICES - 1)) state_nxt = S_STEAL_STOP;
      end

      S_STEAL_STOP: begin
        if (slot_free) begin
          emit = 1'b1;
          if (found_r) begin
            tab_a           = sel_ch;
            tab_op          = T_DN;
            act_cmd         = L_REMOVE;
            act_pos         = best_r;
            steal_v_nxt     = sel_cell[AD-1 -: VW];
            res.event_kind  = EV_STOP;
            res.voice_id    = 4'(sel_cell[AD-1 -: VW]);
            res.voice_chan  = sel_cell[10:7];
            res.voice_key   = sel_cell[6:0];
            res.last_result = 1'b0;
            state_nxt       = S_STEAL_START;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_STEAL_START: begin
        if (slot_free) begin
          act_cmd        = L_PUSH;
          act_new        = {steal_v_r, req_r.chan, req_r.note_key};
          tab_op         = T_UP;
          emit           = 1'b1;
          res.event_kind = EV_START;
          res.voice_id   = 4'(steal_v_r);
          res.voice_chan = req_r.chan;
          res.voice_key  = req_r.note_key;
          state_nxt      = S_IDLE;
        end
      end

      S_ALLOFF: begin
        if (slot_free) begin
          emit = 1'b1;
          if (act_len_r == '0) begin
            tab_op    = T_CLEAR;
            state_nxt = S_IDLE;
          end else begin
            // pop the newest voice onto the free row
            act_cmd         = L_REMOVE;
            act_pos         = '0;
            fr_cmd          = L_PUSH;
            fr_new          = act_q[0][AD-1 -: VW];
            res.event_kind  = EV_STOP;
            res.voice_id    = 4'(act_q[0][AD-1 -: VW]);
            res.voice_chan  = act_q[0][10:7];
            res.voice_key   = act_q[0][6:0];
            res.last_result = (act_len_r == LW'(1));
            if (act_len_r == LW'(1)) begin
              tab_op    = T_CLEAR;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      act_len_r   <= '0;
      fr_len_r    <= LW'(VOICES);
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (act_cmd)
        L_PUSH:   act_len_r <= act_len_r + LW'(1);
        L_REMOVE: act_len_r <= act_len_r - LW'(1);
        default:  act_len_r <= act_len_r;
      endcase
      case (fr_cmd)
        L_PUSH:   fr_len_r <= fr_len_r + LW'(1);
        L_REMOVE: fr_len_r <= fr_len_r - LW'(1);
        default:  fr_len_r <= fr_len_r;
      endcase
    end
  end

  // Payload registers: hold the request, the result being offered and the steal search state.
  always_ff @(posedge clk) begin
    if (in_acc) req_r <= in_data;
    if (emit) out_r <= res;
    bflag_r   <= bflag_nxt;
    bprio_r   <= bprio_nxt;
    best_r    <= best_nxt;
    steal_v_r <= steal_v_nxt;
  end

  // Channel tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_r[c] <= '0;
        res_r[c] <= 7'd1;
        pri_r[c] <= '0;
        flg_r[c] <= 1'b0;
      end
    end else begin
      case (tab_op)
        T_UP: begin
          cnt_r[tab_a] <= cnt_up;
          flg_r[tab_a] <= flag_up;
        end
        T_DN: begin
          cnt_r[tab_a] <= cnt_dn;
          flg_r[tab_a] <= flag_dn;
        end
        T_SETRES: res_r[tab_a] <= req_r.setting_value;
        T_SETPRI: pri_r[tab_a] <= req_r.setting_value;
        T_CLEAR: begin
          // flags stay as they are
          for (int c = 0; c < CHANNELS; c++) begin
            cnt_r[c] <= '0;
            res_r[c] <= 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

`include "synth_voice_allocator_assert.svh"

  // The stolen voice is out of both rows between its stop and its start.
  `SVA_ALWAYS(a_voice_conserved, ((state_r == S_STEAL_START) || (({1'b0, act_len_r} + {1'b0, fr_len_r}) == (LW+1)'(VOICES))), "voice lost or duplicated between rows")
  `SVA_ALWAYS(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `SVA_NEXT(a_accept_exec, in_acc, (state_r == S_EXEC), "accepted request not dispatched")
  `SVA_NEXT(a_scan_end, ((state_r == S_SCAN) && (idx_r == VW'(VOICES - 1))), (state_r == S_STEAL_STOP), "steal search overran the row")
  `SVA_ALWAYS(a_scan_full, ((state_r != S_SCAN) || (fr_len_r == '0)), "steal search with a free voice")

endmodule
